// ===== design/rfalu_pkg.sv =====
package rfalu_pkg;

  // default sizes of the register file
  localparam int unsigned REG_COUNT_DEF  = 10;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed widths of the transaction fields
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned IMM_W   = 32;
  localparam int unsigned OUT_W   = 32;

  // queue depths
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    OP_MOV  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_INC  = 3'd5,
    OP_DEC  = 3'd6,
    OP_KEEP = 3'd7
  } op_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e  op;
    logic dest_ok;
    logic src_is_reg;
    logic src_ok;
  } cmd_ctrl_t;

  // one result transaction
  typedef struct packed {
    logic signed [OUT_W-1:0] dest_value;
    logic                    divide_by_zero;
  } result_t;

endpackage

// ===== design/register_file_alu_executor_top.sv =====
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------------------------
// input     | push / full       | mode_i, dest_index_i, source_is_register_i,
//           |                   | source_index_i, immediate_i
// result    | pop / empty       | dest_value_o, divide_by_zero_o
//
// move, add, subtract, increment, decrement, the unused op, a zero divisor and an
// out-of-range destination finish in the sequencer's execute state; multiply and divide
// go on to the wait state until the shared one-bit-per-cycle unit is done.
// reset clears the queues and marks every register as zero through per-register
// valid bits, with no clearing pass; a command starts only when the result queue has room.
module register_file_alu_executor_top #(
  parameter int unsigned REG_COUNT  = rfalu_pkg::REG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [rfalu_pkg::MODE_W-1:0]       mode_i,
  input  logic [rfalu_pkg::INDEX_W-1:0]      dest_index_i,
  input  logic                               source_is_register_i,
  input  logic [rfalu_pkg::INDEX_W-1:0]      source_index_i,
  input  logic signed [rfalu_pkg::IMM_W-1:0] immediate_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rfalu_pkg::OUT_W-1:0] dest_value_o,
  output logic                               divide_by_zero_o
);

  import rfalu_pkg::*;

  localparam int unsigned IdxW = $clog2(REG_COUNT);
  localparam int unsigned CmdW = $bits(cmd_ctrl_t) + 2 * IdxW + DATA_WIDTH;
  localparam int unsigned ResW = $bits(result_t);

  cmd_ctrl_t             fe_ctrl;
  logic [IdxW-1:0]       fe_dest_idx;
  logic [IdxW-1:0]       fe_src_idx;
  logic [DATA_WIDTH-1:0] fe_operand;
  logic [CmdW-1:0]       cmd_wdata;
  logic [CmdW-1:0]       cmd_rdata;
  logic                  cmd_empty;
  logic                  cmd_pop;

  cmd_ctrl_t             be_ctrl;
  logic [IdxW-1:0]       be_dest_idx;
  logic [IdxW-1:0]       be_src_idx;
  logic [DATA_WIDTH-1:0] be_operand;

  result_t               be_res;
  logic                  be_res_push;
  logic                  res_full;
  logic [ResW-1:0]       res_rdata;
  result_t               res_head;

  // front: classify the instruction
  rfalu_front #(
    .REG_COUNT (REG_COUNT),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .mode_i              (mode_i),
    .dest_index_i        (dest_index_i),
    .source_is_register_i(source_is_register_i),
    .source_index_i      (source_index_i),
    .immediate_i         (immediate_i),
    .ctrl_o              (fe_ctrl),
    .dest_idx_o          (fe_dest_idx),
    .src_idx_o           (fe_src_idx),
    .operand_o           (fe_operand)
  );

  // command queue between front and back
  assign cmd_wdata = {fe_ctrl, fe_dest_idx, fe_src_idx, fe_operand};

  rfalu_fifo #(
    .Width(CmdW),
    .Depth(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_rdata),
    .empty_o(cmd_empty)
  );

  assign {be_ctrl, be_dest_idx, be_src_idx, be_operand} = cmd_rdata;

  // back: register file and execution
  rfalu_back #(
    .REG_COUNT (REG_COUNT),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (~cmd_empty),
    .cmd_ctrl_i    (be_ctrl),
    .cmd_dest_idx_i(be_dest_idx),
    .cmd_src_idx_i (be_src_idx),
    .cmd_operand_i (be_operand),
    .cmd_pop_o     (cmd_pop),
    .res_ready_i   (~res_full),
    .res_push_o    (be_res_push),
    .res_o         (be_res)
  );

  // result queue toward the consumer
  rfalu_fifo #(
    .Width(ResW),
    .Depth(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (be_res_push),
    .data_i (be_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_rdata),
    .empty_o(empty)
  );

  assign res_head         = res_rdata;
  assign dest_value_o     = res_head.dest_value;
  assign divide_by_zero_o = res_head.divide_by_zero;

endmodule

// ===== design/rfalu_fifo.sv =====
module rfalu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok;
  logic             pop_ok;

  // status and head of queue
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/rfalu_front.sv =====
module rfalu_front #(
  parameter int unsigned REG_COUNT  = rfalu_pkg::REG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IdxW      = $clog2(REG_COUNT)
) (
  input  logic [rfalu_pkg::MODE_W-1:0]       mode_i,
  input  logic [rfalu_pkg::INDEX_W-1:0]      dest_index_i,
  input  logic                               source_is_register_i,
  input  logic [rfalu_pkg::INDEX_W-1:0]      source_index_i,
  input  logic signed [rfalu_pkg::IMM_W-1:0] immediate_i,
  output rfalu_pkg::cmd_ctrl_t               ctrl_o,
  output logic [IdxW-1:0]                    dest_idx_o,
  output logic [IdxW-1:0]                    src_idx_o,
  output logic [DATA_WIDTH-1:0]              operand_o
);

  import rfalu_pkg::*;

  op_e op;

  assign op = op_e'(mode_i);

  // classify the instruction
  always_comb begin
    ctrl_o.op      = op;
    ctrl_o.dest_ok = (32'(dest_index_i) < REG_COUNT);
    ctrl_o.src_ok  = (32'(source_index_i) < REG_COUNT);
    unique case (op) inside
      OP_INC, OP_DEC, OP_KEEP: ctrl_o.src_is_reg = 1'b0;
      default:                 ctrl_o.src_is_reg = source_is_register_i;
    endcase
  end

  // index and immediate to internal widths
  assign dest_idx_o = IdxW'(dest_index_i);
  assign src_idx_o  = IdxW'(source_index_i);
  assign operand_o  = DATA_WIDTH'(immediate_i);

endmodule

// ===== design/rfalu_muldiv.sv =====
module rfalu_muldiv #(
  parameter int unsigned DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  is_div_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);

  logic                  busy_q;
  logic                  done_q;
  logic                  is_div_q;
  logic [CntW-1:0]       cnt_q;
  logic [DATA_WIDTH-1:0] x_q;
  logic [DATA_WIDTH-1:0] y_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic [DATA_WIDTH:0]   trial;
  logic                  last;

  // restoring division trial subtract
  assign trial    = {acc_q, x_q[DATA_WIDTH-1]} - {1'b0, y_q};
  assign last     = (cnt_q == CntW'(DATA_WIDTH - 1));
  assign done_o   = done_q;
  assign result_o = is_div_q ? x_q : acc_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q & last;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one bit per cycle: shift-add product or quotient bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      is_div_q <= is_div_i;
      cnt_q    <= '0;
      x_q      <= a_i;
      y_q      <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (is_div_q) begin
        if (!trial[DATA_WIDTH]) begin
          acc_q <= trial[DATA_WIDTH-1:0];
        end else begin
          acc_q <= {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
        end
        x_q <= {x_q[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      end else begin
        acc_q <= acc_q + (y_q[0] ? x_q : '0);
        x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
        y_q   <= {1'b0, y_q[DATA_WIDTH-1:1]};
      end
    end
  end

endmodule

// ===== design/rfalu_back.sv =====
module rfalu_back #(
  parameter int unsigned REG_COUNT  = rfalu_pkg::REG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IdxW      = $clog2(REG_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  rfalu_pkg::cmd_ctrl_t  cmd_ctrl_i,
  input  logic [IdxW-1:0]       cmd_dest_idx_i,
  input  logic [IdxW-1:0]       cmd_src_idx_i,
  input  logic [DATA_WIDTH-1:0] cmd_operand_i,
  output logic                  cmd_pop_o,
  input  logic                  res_ready_i,
  output logic                  res_push_o,
  output rfalu_pkg::result_t    res_o
);

  import rfalu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state_q, state_d;

  logic [DATA_WIDTH-1:0] rf_q [REG_COUNT];
  logic [REG_COUNT-1:0]  rf_vld_q;

  cmd_ctrl_t             ctrl_q;
  logic [IdxW-1:0]       dest_q;
  logic [DATA_WIDTH-1:0] operand_q;
  logic [DATA_WIDTH-1:0] cur_raw_q;
  logic [DATA_WIDTH-1:0] src_raw_q;
  logic                  cur_vld_q;
  logic                  src_vld_q;
  logic                  neg_q;

  logic [DATA_WIDTH-1:0] cur;
  logic [DATA_WIDTH-1:0] src;
  logic [DATA_WIDTH-1:0] cur_mag;
  logic [DATA_WIDTH-1:0] src_mag;
  logic [DATA_WIDTH-1:0] res_val;
  logic signed [DATA_WIDTH-1:0] res_s;
  logic                  res_dz;
  logic                  wr_en;
  logic                  md_start;
  logic                  md_is_div;
  logic [DATA_WIDTH-1:0] md_a;
  logic [DATA_WIDTH-1:0] md_b;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_res;

  // operands; a never written register reads as zero
  assign cur     = cur_vld_q ? cur_raw_q : '0;
  assign src     = ctrl_q.src_is_reg ? (src_vld_q ? src_raw_q : '0) : operand_q;
  assign cur_mag = cur[DATA_WIDTH-1] ? (~cur + 1'b1) : cur;
  assign src_mag = src[DATA_WIDTH-1] ? (~src + 1'b1) : src;
  assign md_a    = md_is_div ? cur_mag : cur;
  assign md_b    = md_is_div ? src_mag : src;

  rfalu_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .is_div_i (md_is_div),
    .a_i      (md_a),
    .b_i      (md_b),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // sequencer and result select
  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    wr_en      = 1'b0;
    res_val    = cur;
    res_dz     = 1'b0;
    md_start   = 1'b0;
    md_is_div  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && res_ready_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!ctrl_q.dest_ok) begin
          res_val    = '0;
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end else begin
          unique case (ctrl_q.op)
            OP_MOV:  res_val = src;
            OP_ADD:  res_val = cur + src;
            OP_SUB:  res_val = cur - src;
            OP_INC:  res_val = cur + 1'b1;
            OP_DEC:  res_val = cur - 1'b1;
            OP_KEEP: res_val = cur;
            OP_MUL:  md_start = 1'b1;
            OP_DIV: begin
              if (src == '0) begin
                res_dz = 1'b1;
              end else begin
                md_start  = 1'b1;
                md_is_div = 1'b1;
              end
            end
            default: res_val = cur;
          endcase
          if (md_start) begin
            state_d = S_WAIT;
          end else begin
            wr_en      = 1'b1;
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        if (md_done) begin
          if (ctrl_q.op == OP_DIV && neg_q) begin
            res_val = ~md_res + 1'b1;
          end else begin
            res_val = md_res;
          end
          wr_en      = 1'b1;
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result transaction, low bits of the sign-extended value
  assign res_s                = res_val;
  assign res_o.dest_value     = OUT_W'(res_s);
  assign res_o.divide_by_zero = res_dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rf_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        rf_vld_q[dest_q] <= 1'b1;
      end
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_q[dest_q] <= res_val;
    end
    if (cmd_pop_o) begin
      cur_raw_q <= rf_q[cmd_dest_idx_i];
      src_raw_q <= rf_q[cmd_src_idx_i];
    end
  end

  // command capture and sign of the quotient
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      ctrl_q    <= cmd_ctrl_i;
      dest_q    <= cmd_dest_idx_i;
      operand_q <= cmd_operand_i;
      cur_vld_q <= cmd_ctrl_i.dest_ok & rf_vld_q[cmd_dest_idx_i];
      src_vld_q <= cmd_ctrl_i.src_ok & rf_vld_q[cmd_src_idx_i];
    end
    if (state_q == S_EXEC) begin
      neg_q <= cur[DATA_WIDTH-1] ^ src[DATA_WIDTH-1];
    end
  end

endmodule

// ===== design/rfalu_checker.sv =====
module rfalu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [rfalu_pkg::OUT_W-1:0] dest_value_o,
  input logic                               divide_by_zero_o
);

  import rfalu_pkg::*;

  // both queues come out of reset with nothing in them
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |-> empty && !full)
    else $error("queue status not cleared by reset");

  // a waiting result stays until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped without pop");

  // its payload does not change while waiting
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(dest_value_o) && $stable(divide_by_zero_o))
    else $error("waiting result changed");

  // the input queue fills only through an accepted transaction
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full raised without an accepted transaction");

endmodule

bind register_file_alu_executor_top rfalu_checker u_checker (.*);
